// ===== rtl/swbd_pkg.sv =====
// Shared types and constants for the sliding-window burst detector.
// No dependencies; every other file imports this package.
package swbd_pkg;

  localparam int RING_DEPTH      = 64;
  localparam int PTR_W           = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W           = $clog2(RING_DEPTH + 1);
  localparam int TS_W            = 32;
  localparam int WSEC_W          = 13;
  localparam int WIN_W           = 23;
  localparam int THR_W           = 7;
  localparam int OCNT_W          = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 13;
  localparam int MS_PER_SEC      = 1000;
  localparam int COUNT_FIELD_MAX = 127;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             enable;
    logic [WIN_W-1:0] span_ms;
    logic [THR_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [TS_W-1:0]  wdata;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/swbd_ring_mem.sv =====
// Timestamp ring storage: one write port, one registered read port.
// Depends on swbd_pkg for depth and request type.
module swbd_ring_mem
  import swbd_pkg::*;
(
  input  logic            clk,
  input  mem_req_t        req,
  output logic [TS_W-1:0] rdata
);

  logic [TS_W-1:0] mem [RING_DEPTH];
  logic [TS_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/swbd_age_cmp.sv =====
// Shared age unit: modulo-2^32 age of a stored stamp against the window.
// Depends on swbd_pkg for widths.
module swbd_age_cmp
  import swbd_pkg::*;
(
  input  logic [TS_W-1:0]  now_ms,
  input  logic [TS_W-1:0]  stamp_ms,
  input  logic [WIN_W-1:0] span_ms,
  output logic             expired
);

  logic [TS_W-1:0] age;

  assign age     = now_ms - stamp_ms;
  assign expired = age > TS_W'(span_ms);

endmodule

// ===== rtl/swbd_ctrl.sv =====
// Sequencer: ring pointers, append, one prune step per cycle, result register.
// Depends on swbd_pkg for the state enum, config and memory request types.
module swbd_ctrl
  import swbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TS_W-1:0]   in_timestamp_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_alarm,
  output logic [OCNT_W-1:0] out_window_count,
  output mem_req_t          mem_req,
  output logic [TS_W-1:0]   now_ms,
  input  logic              expired
);

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    oldest_r, oldest_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TS_W-1:0]     now_r, now_nxt;
  logic                dis_r, dis_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_alarm_r, out_alarm_nxt;
  logic [OCNT_W-1:0]   out_count_r, out_count_nxt;

  logic [PTR_W-1:0]    eff_oldest;
  logic [CNT_W-1:0]    eff_count;
  logic [CNT_W:0]      sum;
  logic [PTR_W-1:0]    wr_addr;
  logic [PTR_W-1:0]    oldest_inc;
  logic [31:0]         count_ext;
  logic                hit;
  logic [OCNT_W-1:0]   reported;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // A full ring drops its oldest entry before the new stamp goes in.
  always_comb begin
    if (count_r == CNT_W'(RING_DEPTH)) begin
      eff_oldest = ptr_inc(oldest_r);
      eff_count  = CNT_W'(RING_DEPTH - 1);
    end else begin
      eff_oldest = oldest_r;
      eff_count  = count_r;
    end
    sum = (CNT_W+1)'(eff_oldest) + (CNT_W+1)'(eff_count);
    if (sum >= (CNT_W+1)'(RING_DEPTH)) begin
      sum = sum - (CNT_W+1)'(RING_DEPTH);
    end
    wr_addr    = sum[PTR_W-1:0];
    oldest_inc = ptr_inc(oldest_r);
    count_ext  = 32'(count_r);
    hit        = count_ext >= 32'(cfg.threshold);
    reported   = (count_ext > 32'(COUNT_FIELD_MAX)) ? OCNT_W'(COUNT_FIELD_MAX)
                                                   : count_ext[OCNT_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    now_nxt       = now_r;
    dis_nxt       = dis_r;
    out_valid_nxt = out_valid_r;
    out_alarm_nxt = out_alarm_r;
    out_count_nxt = out_count_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = wr_addr;
    mem_req.wdata = now_r;
    mem_req.raddr = oldest_inc;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt   = in_timestamp_ms;
          dis_nxt   = !cfg.enable;
          state_nxt = cfg.enable ? ST_APPEND : ST_DONE;
        end
      end
      ST_APPEND: begin
        mem_req.we    = 1'b1;
        mem_req.raddr = eff_oldest;
        oldest_nxt    = eff_oldest;
        count_nxt     = eff_count + CNT_W'(1);
        // A lone new stamp has age zero and can never be pruned.
        state_nxt     = (eff_count == '0) ? ST_DONE : ST_CHECK;
      end
      ST_CHECK: begin
        // Read data is the current oldest; the next entry is fetched meanwhile.
        if (expired && count_r != '0) begin
          oldest_nxt = oldest_inc;
          count_nxt  = count_r - CNT_W'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (dis_r) begin
            out_alarm_nxt = 1'b0;
            out_count_nxt = '0;
          end else begin
            out_alarm_nxt = hit;
            out_count_nxt = reported;
            if (hit) begin
              count_nxt  = '0;
              oldest_nxt = '0;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    dis_r       <= dis_nxt;
    out_alarm_r <= out_alarm_nxt;
    out_count_r <= out_count_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_alarm        = out_alarm_r;
  assign out_window_count = out_count_r;
  assign now_ms           = now_r;

endmodule

// ===== rtl/sliding_window_burst_detector.sv =====
// Sliding-window burst detector. An accepted beat passes the append, prune and
// done states before its result is registered; an empty ring skips prune and a
// disabled detector goes straight to done. Up to RING_DEPTH-1 entries are pruned
// per event, one step per cycle through the shared age compare. One event at a
// time: input stalls until the result issues; a stalled result beat delays it.
// Reset (synchronous, rst_n low) empties the ring and restores the registers.
module sliding_window_burst_detector
  import swbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TS_W-1:0]       in_timestamp_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_alarm,
  output logic [OCNT_W-1:0]     out_window_count
);

  logic             enable_r;
  logic [WIN_W-1:0] span_ms_r;
  logic [THR_W-1:0] threshold_r;
  cfg_t             cfg;
  mem_req_t         mem_req;
  logic [TS_W-1:0]  rdata;
  logic [TS_W-1:0]  now_ms;
  logic             expired;

  // The window is kept in milliseconds, so the multiply happens on the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      span_ms_r   <= WIN_W'(10 * MS_PER_SEC);
      threshold_r <= THR_W'(20);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:    enable_r    <= cfg_wdata[0];
        CFG_WINDOW:    span_ms_r   <= WIN_W'(32'(cfg_wdata) * MS_PER_SEC);
        CFG_THRESHOLD: threshold_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.enable    = enable_r;
  assign cfg.span_ms   = span_ms_r;
  assign cfg.threshold = threshold_r;

  swbd_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_timestamp_ms  (in_timestamp_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_alarm        (out_alarm),
    .out_window_count (out_window_count),
    .mem_req          (mem_req),
    .now_ms           (now_ms),
    .expired          (expired)
  );

  swbd_ring_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  swbd_age_cmp u_age (
    .now_ms   (now_ms),
    .stamp_ms (rdata),
    .span_ms  (span_ms_r),
    .expired  (expired)
  );

endmodule

// ===== rtl/swbd_checker.sv =====
// Port-level assertions for the burst detector, bound to the top level.
// Depends on swbd_pkg for widths and ring depth.
module swbd_checker
  import swbd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_we,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_alarm,
  input logic [OCNT_W-1:0] out_window_count
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_alarm) && $stable(out_window_count))
    else $error("result beat changed while stalled");

  // An accepted event keeps the input stalled on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while an event is in work");

  // An alarm always counts at least the event that raised it.
  a_alarm_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm |-> out_window_count != '0)
    else $error("alarm with empty window");

  // The window never holds more events than the ring.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_window_count) <= RING_DEPTH)
    else $error("window count above ring depth");

  // Registers are written only while the detector is idle and has no result out.
  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_stall && !out_valid)
    else $error("register write while an event is in work");

endmodule

bind sliding_window_burst_detector swbd_checker u_swbd_checker (.*);

// ===== bench/sliding_window_burst_detector_tb.sv =====
// Self-checking testbench for sliding_window_burst_detector: a clocked driver
// and monitor with random idling, checked against a cycle-free burst predictor.
// Depends on swbd_pkg and the detector RTL only.
`timescale 1ns / 100ps

module sliding_window_burst_detector_tb
  import swbd_pkg::*;
();

  typedef struct packed {
    logic              alarm;
    logic [OCNT_W-1:0] window_count;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TS_W-1:0]       in_timestamp_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_alarm;
  logic [OCNT_W-1:0]     out_window_count;

  // Predictor state: a mirror of the event ring and of the registers.
  logic [TS_W-1:0]   stamp_ring [RING_DEPTH];
  int unsigned       ring_head = 0;
  int unsigned       ring_fill = 0;
  logic              det_enable = 1'b1;
  logic [WSEC_W-1:0] det_window_sec = WSEC_W'(10);
  logic [THR_W-1:0]  det_threshold = THR_W'(20);

  logic [TS_W-1:0] stamp_queue [$];
  verdict_t        burst_verdicts [$];
  int unsigned     mismatch_count = 0;
  int unsigned     send_idle_pct = 37;
  int unsigned     recv_stall_pct = 66;

  sliding_window_burst_detector dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_timestamp_ms  (in_timestamp_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_alarm        (out_alarm),
    .out_window_count (out_window_count)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void predict_burst(input logic [TS_W-1:0] stamp);
    verdict_t    v;
    int unsigned span_ms;
    logic [TS_W-1:0] age;
    v = '0;
    if (det_enable) begin
      // A full ring drops its oldest entry to make room.
      if (ring_fill >= RING_DEPTH) begin
        ring_head = (ring_head + 1) % RING_DEPTH;
        ring_fill = RING_DEPTH - 1;
      end
      stamp_ring[(ring_head + ring_fill) % RING_DEPTH] = stamp;
      ring_fill++;
      span_ms = int'(det_window_sec) * MS_PER_SEC;
      while (ring_fill > 0) begin
        age = stamp - stamp_ring[ring_head];
        if (age <= span_ms) break;
        ring_head = (ring_head + 1) % RING_DEPTH;
        ring_fill--;
      end
      v.window_count = OCNT_W'((ring_fill > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : ring_fill);
      if (ring_fill >= det_threshold) begin
        v.alarm   = 1'b1;
        ring_fill = 0;
        ring_head = 0;
      end
    end
    burst_verdicts = {burst_verdicts, v};
  endfunction

  // Driver: a new beat is offered only once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_burst(in_timestamp_ms);
      if (!in_valid || !in_stall) begin
        if (stamp_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid        <= 1'b1;
          in_timestamp_ms <= stamp_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (burst_verdicts.size() == 0) begin
          report_mismatch("result beat with no prediction pending");
        end else begin
          exp_v = burst_verdicts.pop_front();
          if (out_alarm !== exp_v.alarm)
            report_mismatch($sformatf("alarm %0b, expected %0b", out_alarm, exp_v.alarm));
          if (out_window_count !== exp_v.window_count)
            report_mismatch($sformatf("window_count %0d, expected %0d",
                                      out_window_count, exp_v.window_count));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (stamp_queue.size() != 0 || in_valid || burst_verdicts.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
  endtask

  // Registers only change once the detector has returned every result.
  task automatic apply_settings(input logic en, input int unsigned wsec,
                                input int unsigned thr);
    wait_drained();
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_WINDOW, wsec);
    write_reg(CFG_THRESHOLD, thr);
    @(posedge clk);
    cfg_we         <= 1'b0;
    det_enable     = en;
    det_window_sec = WSEC_W'(wsec);
    det_threshold  = THR_W'(thr);
    @(negedge clk);
  endtask

  initial begin
    logic [TS_W-1:0] ts;
    logic            en;
    int unsigned     wsec, thr, seg_len, hi, pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: wrap of the stamp and a stamp that goes backward.
    stamp_queue = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd3, 32'd20000};
    // Zero window: only equal stamps share the window.
    apply_settings(1'b1, 0, 2);
    stamp_queue = '{32'd100, 32'd100, 32'd101, 32'd102};
    // Threshold zero fires on every event.
    apply_settings(1'b1, 8191, 0);
    stamp_queue = '{32'd7, 32'hFFFF_FFFF};
    apply_settings(1'b0, 8191, 1);
    stamp_queue = '{32'd50, 32'd60};
    // Disabled events must leave the ring untouched.
    apply_settings(1'b1, 5, 3);
    stamp_queue = '{32'd1000, 32'd2000};
    apply_settings(1'b0, 5, 3);
    stamp_queue = '{32'd2500};
    apply_settings(1'b1, 5, 3);
    stamp_queue = '{32'd3000};
    // Age equal to the window is kept, one past it is pruned.
    apply_settings(1'b1, 4294, 64);
    stamp_queue = '{32'h7FFF_FFFF, 32'h7FFF_FFFF + 32'd4294000, 32'h7FFF_FFFF + 32'd4294001};

    ts = $urandom;
    for (int seg = 0; seg < 10; seg++) begin
      if (seg == 2) begin
        en = 1'b1; wsec = 8191; thr = 127;
      end else if (seg == 6) begin
        en = 1'b1; wsec = 8191; thr = 64;
      end else if (seg == 9) begin
        en = 1'b1; wsec = 4294; thr = 65;
      end else begin
        en   = ($urandom_range(9) != 0);
        pick = $urandom_range(5);
        unique case (pick)
          0: wsec = 0;
          1: wsec = 1;
          2: wsec = 2;
          3: wsec = 10;
          4: wsec = 8191;
          default: wsec = $urandom_range(0, 4294);
        endcase
        pick = $urandom_range(9);
        if (pick == 0)      thr = 0;
        else if (pick == 1) thr = 127;
        else if (pick == 2) thr = $urandom_range(65, 126);
        else                thr = $urandom_range(1, 64);
      end
      apply_settings(en, wsec, thr);
      if (seg == 4) begin
        send_idle_pct  = 66;
        recv_stall_pct = 37;
      end else if (seg == 8) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      seg_len = (thr > RING_DEPTH || seg == 6) ? $urandom_range(66, 80) : $urandom_range(8, 25);
      // Mean step scaled so that roughly a threshold's worth of events fit a window.
      hi = (wsec * MS_PER_SEC * 2) / ((thr == 0) ? 1 : thr) + 1;
      if (thr > RING_DEPTH || seg == 6) hi = 50;
      for (int i = 0; i < seg_len; i++) begin
        pick = $urandom_range(99);
        if (pick < 4)      ts = $urandom;
        else if (pick < 8) ts = ts - $urandom_range(1, 5000);
        else               ts = ts + $urandom_range(0, hi);
        stamp_queue = {stamp_queue, ts};
      end
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (burst_verdicts.size() != 0)
      report_mismatch($sformatf("%0d predictions never answered", burst_verdicts.size()));
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
